FILE: rtl/core/comma_list_token_search_core_macros.svh
// Assertion macros used by the checker file of the token search core.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef COMMA_LIST_TOKEN_SEARCH_CORE_MACROS_SVH
`define COMMA_LIST_TOKEN_SEARCH_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CLTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CLTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/clts_pkg.sv
// Shared types and constants of the token search core.
// No dependencies; every other file of the block but the macro header imports it.
package clts_pkg;

  localparam int KEY_W      = 128;
  localparam int KEY_LEN_W  = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ANSWER_W   = 17;

  localparam logic [7:0] COMMA_BYTE = 8'd44;

  localparam logic [CFG_ADDR_W-1:0] REG_KEY_BYTES_LOW       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_BYTES_HIGH      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LENGTH          = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REPORT_TOKEN_NUMBER = 3'd3;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [KEY_LEN_W-1:0] key_length;
    logic                 report_token_number;
  } cfg_t;

  typedef struct packed {
    logic                found;
    logic [ANSWER_W-1:0] answer;
  } result_t;

endpackage

FILE: rtl/core/clts_ifs.sv
// Valid/ready channel interfaces of the token search core: list bytes in,
// results out, register writes. Depends on clts_pkg.
interface clts_in_if;
  import clts_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] list_byte;
  logic       list_end;
  modport source (output valid, list_byte, list_end, input ready);
  modport sink   (input valid, list_byte, list_end, output ready);
endinterface

interface clts_out_if;
  import clts_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [ANSWER_W-1:0] answer;
  modport source (output valid, found, answer, input ready);
  modport sink   (input valid, found, answer, output ready);
endinterface

interface clts_cfg_if;
  import clts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

FILE: rtl/core/clts_cfg_regs.sv
// Configuration registers of the token search core: key bytes, key length
// and report mode. Depends on clts_pkg and clts_ifs.
module clts_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  clts_cfg_if.sink       cfg_if,
  output clts_pkg::cfg_t cfg
);
  import clts_pkg::*;

  cfg_t cfg_r;

  assign cfg_if.ready = 1'b1;
  assign cfg         = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.addr)
        REG_KEY_BYTES_LOW:       cfg_r.key[63:0]            <= cfg_if.data;
        REG_KEY_BYTES_HIGH:      cfg_r.key[127:64]          <= cfg_if.data;
        REG_KEY_LENGTH:          cfg_r.key_length          <= cfg_if.data[KEY_LEN_W-1:0];
        REG_REPORT_TOKEN_NUMBER: cfg_r.report_token_number <= cfg_if.data[0];
        default: begin
          // drop writes to unused addresses
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/clts_tok_match.sv
// Next-state logic of the scanner: key byte compare, token close, counter
// updates and the result of a list's final byte. Depends on clts_pkg.
module clts_tok_match #(
  parameter  int KEY_BYTES      = 16,
  parameter  int MAX_LIST_BYTES = 65536,
  localparam int CW             = $clog2(MAX_LIST_BYTES + 1),
  localparam int OW             = $clog2(KEY_BYTES + 1)
) (
  input  clts_pkg::cfg_t    cfg,
  input  logic [7:0]        list_byte,
  input  logic              list_end,
  input  logic [CW-1:0]     pos,
  input  logic [CW-1:0]     tnum,
  input  logic [CW-1:0]     tstart,
  input  logic [OW-1:0]     off,
  input  logic              still,
  input  logic              seen,
  input  logic [CW-1:0]     ans,
  output logic [CW-1:0]     pos_nxt,
  output logic [CW-1:0]     tnum_nxt,
  output logic [CW-1:0]     tstart_nxt,
  output logic [OW-1:0]     off_nxt,
  output logic              still_nxt,
  output logic              seen_nxt,
  output logic [CW-1:0]     ans_nxt,
  output clts_pkg::result_t res
);
  import clts_pkg::*;

  localparam logic [CW-1:0] MAX_C = CW'(MAX_LIST_BYTES);

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == MAX_C) ? MAX_C : v + 1'b1;
  endfunction

  logic [OW-1:0] len;
  logic [7:0]    off8;
  logic [7:0]    kb;
  logic          is_comma;
  logic          byte_ok;
  logic [OW-1:0] off_adv;
  logic [OW-1:0] chk_off;
  logic          chk_still;
  logic          hit;
  logic          seen_new;
  logic [CW-1:0] ans_new;

  always_comb begin
    len  = (32'(cfg.key_length) > KEY_BYTES) ? OW'(KEY_BYTES) : OW'(cfg.key_length);
    off8 = 8'(off);
    // key bytes past the sixteen held in registers read as zero
    kb   = (off8 < 8'd16) ? cfg.key[{off8[3:0], 3'b000} +: 8] : 8'd0;

    is_comma = (list_byte == COMMA_BYTE);
    byte_ok  = still && (off < len) && (list_byte == kb);
    off_adv  = byte_ok ? off + 1'b1 : off;

    // a comma closes the token as it stood; a final data byte closes it after the update
    chk_off   = is_comma ? off : off_adv;
    chk_still = is_comma ? still : byte_ok;
    hit       = (is_comma || list_end) && !seen && (len != '0) && chk_still &&
                (chk_off == len);
    seen_new  = seen || hit;
    ans_new   = hit ? (cfg.report_token_number ? tnum : sat_inc(tstart)) : ans;

    res.found  = seen_new;
    res.answer = seen_new ? ANSWER_W'(ans_new) : '0;

    if (list_end) begin
      pos_nxt    = '0;
      tnum_nxt   = CW'(1);
      tstart_nxt = '0;
      off_nxt    = '0;
      still_nxt  = 1'b1;
      seen_nxt   = 1'b0;
      ans_nxt    = '0;
    end else begin
      pos_nxt  = sat_inc(pos);
      seen_nxt = seen_new;
      ans_nxt  = ans_new;
      if (is_comma) begin
        tnum_nxt   = sat_inc(tnum);
        tstart_nxt = sat_inc(pos);
        off_nxt    = '0;
        still_nxt  = 1'b1;
      end else begin
        tnum_nxt   = tnum;
        tstart_nxt = tstart;
        off_nxt    = off_adv;
        still_nxt  = byte_ok;
      end
    end
  end

endmodule

FILE: rtl/core/comma_list_token_search_core.sv
// Top level of the comma-separated list token search core: input register,
// scan state, result register. Depends on clts_pkg, clts_ifs, clts_cfg_regs
// and clts_tok_match.
//
// Usage:
//   in_if  carries one list byte per request with list_end on the final byte.
//   out_if carries one result (found, answer) per list, after its final byte.
//   cfg_if writes the key bytes, key length and report mode; it is always
//   ready, and must be written by the user only while no list is in flight.
//   The block itself does not enforce this.
// Output: the scan stage loads the result register, raising out_if.valid.
// Throughput: one list byte per cycle while no final byte waits for room;
//   the scan stage updates all counters and compares one key byte per step.
// Reset: rst_n is synchronous; it clears the config registers, the scan state
//   and both valid flags, and holds in_if.ready low while asserted.
// Stall: a result waits in the result register until out_if.ready; bytes
//   that are not the final byte keep streaming meanwhile, and the next final
//   byte waits in the input register, which then drops in_if.ready.
module comma_list_token_search_core #(
  parameter int KEY_BYTES      = 16,
  parameter int MAX_LIST_BYTES = 65536
) (
  input  logic       clk,
  input  logic       rst_n,
  clts_in_if.sink    in_if,
  clts_out_if.source out_if,
  clts_cfg_if.sink   cfg_if
);
  import clts_pkg::*;

  localparam int CW = $clog2(MAX_LIST_BYTES + 1);
  localparam int OW = $clog2(KEY_BYTES + 1);

  cfg_t cfg;

  logic          s_valid_r;
  logic [7:0]    s_byte_r;
  logic          s_last_r;
  logic          s_fire;

  logic [CW-1:0] pos_r, tnum_r, tstart_r, ans_r;
  logic [OW-1:0] off_r;
  logic          still_r, seen_r;

  logic [CW-1:0] pos_nxt, tnum_nxt, tstart_nxt, ans_nxt;
  logic [OW-1:0] off_nxt;
  logic          still_nxt, seen_nxt;
  result_t       res;

  logic          out_valid_r;
  result_t       out_res_r;

  clts_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  clts_tok_match #(
    .KEY_BYTES      (KEY_BYTES),
    .MAX_LIST_BYTES (MAX_LIST_BYTES)
  ) u_tok_match (
    .cfg        (cfg),
    .list_byte  (s_byte_r),
    .list_end   (s_last_r),
    .pos        (pos_r),
    .tnum       (tnum_r),
    .tstart     (tstart_r),
    .off        (off_r),
    .still      (still_r),
    .seen       (seen_r),
    .ans        (ans_r),
    .pos_nxt    (pos_nxt),
    .tnum_nxt   (tnum_nxt),
    .tstart_nxt (tstart_nxt),
    .off_nxt    (off_nxt),
    .still_nxt  (still_nxt),
    .seen_nxt   (seen_nxt),
    .ans_nxt    (ans_nxt),
    .res        (res)
  );

  // only a final byte needs room in the result register
  assign s_fire      = s_valid_r && (!s_last_r || !out_valid_r || out_if.ready);
  assign in_if.ready = rst_n && (!s_valid_r || s_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s_byte_r <= in_if.list_byte;
      s_last_r <= in_if.list_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      tnum_r   <= CW'(1);
      tstart_r <= '0;
      off_r    <= '0;
      still_r  <= 1'b1;
      seen_r   <= 1'b0;
      ans_r    <= '0;
    end else if (s_fire) begin
      pos_r    <= pos_nxt;
      tnum_r   <= tnum_nxt;
      tstart_r <= tstart_nxt;
      off_r    <= off_nxt;
      still_r  <= still_nxt;
      seen_r   <= seen_nxt;
      ans_r    <= ans_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s_fire && s_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.found  = out_res_r.found;
  assign out_if.answer = out_res_r.answer;

endmodule

FILE: rtl/core/clts_checker.sv
// Port-level assertions of the token search core, bound to the top level.
// Depends on clts_pkg and comma_list_token_search_core_macros.svh.
`include "comma_list_token_search_core_macros.svh"

module clts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_list_end,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_found,
  input logic [clts_pkg::ANSWER_W-1:0] out_answer
);
  import clts_pkg::*;

  // a stalled result holds
  `CLTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_found) && $stable(out_answer), "stalled result changed")

  `CLTS_ASSERT_SAME(a_zero_when_absent, out_valid && !out_found, out_answer == '0,
    "answer not zero without a match")

  // a fresh result follows an accepted final byte
  `CLTS_ASSERT_SAME(a_result_after_end, $rose(out_valid),
    $past(in_valid && in_ready && in_list_end, 2), "result without a final byte")

  // the input side only stalls behind a stalled result
  `CLTS_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready,
    "input stalled while result side free")

endmodule

bind comma_list_token_search_core clts_checker u_clts_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .in_list_end (in_if.list_end),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_found   (out_if.found),
  .out_answer  (out_if.answer)
);

FILE: tb/tb_top.sv
// Self-checking testbench of comma_list_token_search_core: streams comma-separated
// lists under random idling and back-pressure and checks every result against a
// predictor of the scan. Depends on clts_pkg, clts_ifs and the core itself.
module tb_top;
  import clts_pkg::*;

  localparam int KEY_BYTES      = 16;
  localparam int LIST_CAP       = 65536;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 400;

  // Predicts the result of each list and holds the results still to come.
  class search_result_board;
    logic [KEY_W-1:0]     key;
    logic [KEY_LEN_W-1:0] key_len;
    logic                 by_token;

    logic [ANSWER_W-1:0]  byte_pos;
    logic [ANSWER_W-1:0]  tok_num;
    logic [ANSWER_W-1:0]  tok_start;
    logic [KEY_LEN_W-1:0] tok_off;
    logic                 tok_live;
    logic                 hit_seen;
    logic [ANSWER_W-1:0]  hit_answer;

    result_t     awaited[$];
    int unsigned fails;

    function new();
      key      = '0;
      key_len  = '0;
      by_token = 1'b0;
      fails    = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      byte_pos   = '0;
      tok_num    = ANSWER_W'(1);
      tok_start  = '0;
      tok_off    = '0;
      tok_live   = 1'b1;
      hit_seen   = 1'b0;
      hit_answer = '0;
    endfunction

    function logic [ANSWER_W-1:0] sat_inc(logic [ANSWER_W-1:0] v);
      return (v >= LIST_CAP) ? ANSWER_W'(LIST_CAP) : v + 1'b1;
    endfunction

    function logic [KEY_LEN_W-1:0] used_len();
      return (key_len > KEY_BYTES) ? KEY_LEN_W'(KEY_BYTES) : key_len;
    endfunction

    function void close_token();
      logic [KEY_LEN_W-1:0] len;
      len = used_len();
      if (!hit_seen && len != 0 && tok_live && tok_off == len) begin
        hit_seen   = 1'b1;
        hit_answer = by_token ? tok_num : sat_inc(tok_start);
      end
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        REG_KEY_BYTES_LOW:       key[63:0]   = data;
        REG_KEY_BYTES_HIGH:      key[127:64] = data;
        REG_KEY_LENGTH:          key_len     = data[KEY_LEN_W-1:0];
        REG_REPORT_TOKEN_NUMBER: by_token    = data[0];
        default: ;
      endcase
    endfunction

    // Advance the scan by one accepted request; queue a result on the last byte.
    function void take_byte(logic [7:0] b, logic last);
      logic [KEY_LEN_W-1:0] len;
      result_t              r;
      len = used_len();
      if (b == COMMA_BYTE) begin
        close_token();
        tok_num   = sat_inc(tok_num);
        tok_start = sat_inc(byte_pos);
        tok_off   = '0;
        tok_live  = 1'b1;
      end else if (tok_live && tok_off < len && b == key[8*int'(tok_off) +: 8]) begin
        tok_off = tok_off + 1'b1;
      end else begin
        tok_live = 1'b0;
      end
      byte_pos = sat_inc(byte_pos);
      if (last) begin
        if (b != COMMA_BYTE) close_token();
        r.found  = hit_seen;
        r.answer = hit_seen ? hit_answer : '0;
        awaited.push_back(r);
        clear_scan();
      end
    endfunction

    function void match_result(logic found, logic [ANSWER_W-1:0] answer);
      result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result found=%0d answer=%0d", $time, found, answer);
        fails++;
      end else begin
        want = awaited.pop_front();
        if (found !== want.found) begin
          $display("%0t: found mismatch: expected %0d, actual %0d",
                   $time, want.found, found);
          fails++;
        end
        if (answer !== want.answer) begin
          $display("%0t: answer mismatch: expected %0d, actual %0d",
                   $time, want.answer, answer);
          fails++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  clts_in_if  in_ch ();
  clts_out_if out_ch ();
  clts_cfg_if cfg_ch ();

  comma_list_token_search_core #(
    .KEY_BYTES     (KEY_BYTES),
    .MAX_LIST_BYTES(LIST_CAP)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  search_result_board board;
  logic [7:0]         list_buf[$];
  int                 items_sent;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  bit                 hold_req;
  bit                 hold_done;
  int                 hold_left;

  always #5 clk = ~clk;

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.list_byte = b;
    in_ch.list_end  = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.take_byte(b, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_list();
    for (int i = 0; i < list_buf.size(); i++)
      send_byte(list_buf[i], i == list_buf.size() - 1);
    list_buf.delete();
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    cfg_ch.valid = 1'b1;
    cfg_ch.addr  = a;
    cfg_ch.data  = d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.write_reg(a, d);
    @(negedge clk);
  endtask

  // Junk in the unused upper bits of the narrow registers must be dropped.
  task automatic set_config(input logic [KEY_W-1:0] k, input int len, input logic mode);
    logic [CFG_DATA_W-1:0] d;
    write_reg(REG_KEY_BYTES_LOW, k[63:0]);
    write_reg(REG_KEY_BYTES_HIGH, k[127:64]);
    d = {$urandom, $urandom};
    d[KEY_LEN_W-1:0] = len[KEY_LEN_W-1:0];
    write_reg(REG_KEY_LENGTH, d);
    d = {$urandom, $urandom};
    d[0] = mode;
    write_reg(REG_REPORT_TOKEN_NUMBER, d);
    cfg_ch.valid = 1'b0;
  endtask

  // Drop valid, drain every pending result, then let the pipeline settle.
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] key_of(string s);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < KEY_BYTES; i++) k[8*i +: 8] = s[i];
    return k;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) list_buf.push_back(s[i]);
  endfunction

  task automatic pick_config();
    logic [KEY_W-1:0] k;
    int               len;
    for (int i = 0; i < KEY_BYTES; i++) begin
      k[8*i +: 8] = 8'($urandom_range(255));
      // keep most keys comma-free so that matches are reachable
      if (k[8*i +: 8] == COMMA_BYTE && $urandom_range(7) != 0) k[8*i +: 8] = 8'h61;
    end
    case ($urandom_range(9))
      0: len = 0;
      1: len = KEY_BYTES;
      2: len = $urandom_range(31, KEY_BYTES + 1);
      default: len = $urandom_range(4, 1);
    endcase
    set_config(k, len, 1'($urandom_range(1)));
  endtask

  task automatic build_random_list();
    int         ntok;
    int         len;
    int         pos;
    logic [7:0] b;
    len = board.used_len();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(20, 1)) list_buf.push_back(8'($urandom_range(255)));
    end else begin
      ntok = $urandom_range(6, 1);
      for (int t = 0; t < ntok; t++) begin
        if (t != 0) list_buf.push_back(COMMA_BYTE);
        case ($urandom_range(8))
          0, 1, 2: for (int i = 0; i < len; i++) list_buf.push_back(board.key[8*i +: 8]);
          3: for (int i = 0; i < len - 1; i++) list_buf.push_back(board.key[8*i +: 8]);
          4: begin
            for (int i = 0; i < len; i++) list_buf.push_back(board.key[8*i +: 8]);
            b = 8'($urandom_range(255));
            if (b == COMMA_BYTE) b = 8'h7A;
            list_buf.push_back(b);
          end
          5: begin
            pos = (len > 0) ? $urandom_range(len - 1) : 0;
            for (int i = 0; i < len; i++) begin
              b = board.key[8*i +: 8];
              if (i == pos) b = b ^ 8'($urandom_range(255, 1));
              list_buf.push_back(b);
            end
          end
          6: ;
          default: repeat ($urandom_range(5, 1)) list_buf.push_back(8'($urandom_range(255)));
        endcase
      end
      if ($urandom_range(5) == 0) list_buf.push_back(COMMA_BYTE);
    end
    if (list_buf.size() == 0) list_buf.push_back(8'($urandom_range(255)));
  endtask

  // Receiver: random stalls plus one long hold-off while the sender keeps going.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        if (hold_req && !hold_done) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) board.match_result(out_ch.found, out_ch.answer);
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int rand_start;
    int done;
    board           = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.list_byte = '0;
    in_ch.list_end  = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.addr     = '0;
    cfg_ch.data     = '0;
    items_sent      = 0;
    send_idle_pct   = 31;
    recv_idle_pct   = 47;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Registers at reset: empty key never matches.
    push_text("a");
    send_list();
    wait_idle();
    // Leading empty token, first of two matches wins, byte offset mode.
    set_config(key_of("ab"), 2, 1'b0);
    push_text(",ab,ab");
    send_list();
    wait_idle();
    // Token number mode with a trailing comma.
    set_config(key_of("ab"), 2, 1'b1);
    push_text("x,ab,");
    send_list();
    wait_idle();
    // A comma inside the key can never match.
    set_config(key_of("a,"), 2, 1'b0);
    push_text("a,a,");
    send_list();
    wait_idle();
    // Oversized key length acts as the full sixteen bytes.
    set_config({KEY_W{1'b1}}, 31, 1'b0);
    list_buf.push_back(8'hFF);
    send_list();
    wait_idle();
    set_config({KEY_W{1'b1}}, 1, 1'b1);
    list_buf.push_back(8'hFF);
    send_list();
    wait_idle();
    set_config('0, 1, 1'b1);
    list_buf.push_back(COMMA_BYTE);
    list_buf.push_back(8'h00);
    send_list();
    wait_idle();

    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      done = items_sent - rand_start;
      if (done < RANDOM_ITEMS / 3) begin
        send_idle_pct = 31;
        recv_idle_pct = 47;
      end else if (done < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (done >= 300) hold_req = 1'b1;
      pick_config();
      repeat ($urandom_range(8, 3)) begin
        build_random_list();
        send_list();
      end
      wait_idle();
    end

    if (board.awaited.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, board.awaited.size());
      board.fails++;
    end
    if (board.fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: comma_list_token_search_core.f
+incdir+rtl/core
rtl/core/clts_pkg.sv
rtl/core/clts_ifs.sv
rtl/core/clts_cfg_regs.sv
rtl/core/clts_tok_match.sv
rtl/core/comma_list_token_search_core.sv
rtl/core/clts_checker.sv
tb/tb_top.sv
